### sv/tcr_pkg.sv
package tcr_pkg;

    // Texture geometry: square textures, edge a power of two
    localparam int TEX_LOG2      = 6;
    localparam int TEX_SIZE      = 1 << TEX_LOG2;
    localparam int FACES         = 4;
    localparam int FACE_WORDS    = TEX_SIZE * TEX_SIZE;
    localparam int STORE_WORDS   = FACES * FACE_WORDS;
    localparam int STORE_AW      = $clog2(STORE_WORDS);
    localparam int FACE_W        = (FACES > 1) ? $clog2(FACES) : 1;

    // Screen geometry
    localparam int SCREEN_WIDTH  = 2048;
    localparam int SCREEN_HEIGHT = 1024;
    localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT);

    // Step divider: dividend is TEX_SIZE << 16
    localparam int DIV_W         = TEX_LOG2 + 17;
    localparam int DIV_CNT_W     = $clog2(DIV_W);

    // Opcodes on the input channel
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_EMIT  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_START,
        CMD_EMIT
    } cmd_t;

    // Classified request passed from front to back
    typedef struct packed {
        cmd_t              cmd;
        logic [31:0]       texel;
        logic [10:0]       column;
        logic [FACE_W-1:0] face;
        logic [9:0]        draw_start;
        logic [10:0]       draw_end;
        logic [15:0]       line_height;
        logic [15:0]       hit_pos;
        logic [31:0]       hit_dir;
        logic [31:0]       perp_dist;
    } req_t;

    // side mod FACES by repeated subtract (side is only 2 bits)
    function automatic logic [FACE_W-1:0] face_of(input logic [1:0] side);
        logic [3:0] s;
        s = {2'b00, side};
        for (int i = 0; i < 3; i++) begin
            if (s >= 4'(FACES)) begin
                s = s - 4'(FACES);
            end
        end
        return FACE_W'(s);
    endfunction

endpackage

### sv/tcr_ram.sv
module tcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/tcr_front.sv
module tcr_front import tcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_texel_value,
    input  logic [10:0] s_column,
    input  logic [1:0]  s_side,
    input  logic [9:0]  s_draw_start,
    input  logic [10:0] s_draw_end,
    input  logic [15:0] s_line_height,
    input  logic [31:0] s_player_x,
    input  logic [31:0] s_player_y,
    input  logic [31:0] s_perp_dist,
    input  logic signed [31:0] s_ray_dir_x,
    input  logic signed [31:0] s_ray_dir_y,
    output logic        q_valid,
    output req_t        q_req,
    input  logic        q_pop
);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    req_t              q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    req_t req_in;
    logic known_op;
    logic push;

    // classify: decode opcode, pick axis, fold face, fix zero height
    always_comb begin
        req_in = '0;
        known_op = 1'b1;
        case (s_opcode)
            OP_LOAD:  req_in.cmd = CMD_LOAD;
            OP_START: req_in.cmd = CMD_START;
            OP_EMIT:  req_in.cmd = CMD_EMIT;
            default: begin
                req_in.cmd = CMD_EMIT;
                known_op = 1'b0;
            end
        endcase
        req_in.texel       = s_texel_value;
        req_in.column      = s_column;
        req_in.face        = face_of(s_side);
        req_in.draw_start  = s_draw_start;
        req_in.draw_end    = s_draw_end;
        req_in.line_height = (s_line_height == 16'd0) ? 16'd1 : s_line_height;
        req_in.perp_dist   = s_perp_dist;
        if (s_side[0] == 1'b0) begin
            req_in.hit_pos = s_player_y[15:0];
            req_in.hit_dir = s_ray_dir_y;
        end else begin
            req_in.hit_pos = s_player_x[15:0];
            req_in.hit_dir = s_ray_dir_x;
        end
    end

    assign s_ready = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign push    = s_valid && s_ready && known_op;
    assign q_valid = (count_reg != '0);
    assign q_req   = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && q_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= req_in;
        end
    end

endmodule

### sv/tcr_back.sv
module tcr_back import tcr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  req_t                 q_req,
    output logic                 q_pop,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_wdata,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [20:0]          m_pixel_addr,
    output logic [31:0]          m_color,
    output logic                 m_last
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MUL,
        ST_DIV,
        ST_POS
    } state_t;

    typedef enum logic [1:0] {
        PIX_CEIL,
        PIX_TEX,
        PIX_FLOOR
    } pix_kind_t;

    state_t              state_reg;
    logic [STORE_AW-1:0] load_ptr_reg;
    logic                active_reg;
    logic [10:0]         column_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [31:0]         pos_reg;
    logic [31:0]         step_reg;
    logic [TEX_LOG2-1:0] tex_col_reg;
    logic [FACE_W-1:0]   face_reg;
    logic [9:0]          first_row_reg;
    logic [10:0]         end_row_reg;
    logic [31:0]         ceil_reg;
    logic [31:0]         floor_reg;

    // start setup operands
    logic [15:0]          hit_pos_reg;
    logic [31:0]          hit_dir_reg;
    logic [31:0]          perp_reg;
    logic [15:0]          lh_reg;
    logic [31:0]          offs_reg;
    logic [31:0]          prod_reg;
    logic [15:0]          rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    // pixel pipeline: read stage and output register
    logic       b_valid_reg;
    pix_kind_t  b_kind_reg;
    logic [20:0] b_paddr_reg;
    logic       b_last_reg;
    logic       m_valid_reg;
    logic [20:0] m_pixel_addr_reg;
    logic [31:0] m_color_reg;
    logic       m_last_reg;

    logic [31:0] ram_rdata;

    // shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_full;

    logic        out_adv;
    logic        issue_ok;
    logic        issue;
    logic        do_load;
    logic        do_start;
    pix_kind_t   kind_next;
    logic        last_next;
    logic [STORE_AW-1:0] tex_addr;
    logic [20:0] paddr_next;
    logic [15:0] frac_next;
    logic [16:0] div_sh;
    logic        div_bit;
    logic        div_q;
    logic [15:0] rem_next;
    logic [31:0] color_next;

    assign out_adv  = b_valid_reg && (!m_valid_reg || m_ready);
    assign issue_ok = !b_valid_reg || out_adv;

    always_comb begin
        q_pop    = 1'b0;
        issue    = 1'b0;
        do_load  = 1'b0;
        do_start = 1'b0;
        if (q_valid && state_reg == ST_RUN) begin
            case (q_req.cmd)
                CMD_LOAD: begin
                    q_pop   = 1'b1;
                    do_load = 1'b1;
                end
                CMD_START: begin
                    q_pop    = 1'b1;
                    do_start = 1'b1;
                end
                CMD_EMIT: begin
                    if (!active_reg) begin
                        q_pop = 1'b1;       // nothing in progress: drop
                    end else if (issue_ok) begin
                        q_pop = 1'b1;
                        issue = 1'b1;
                    end
                end
                default: q_pop = 1'b1;
            endcase
        end
    end

    // row classification for the next pixel
    always_comb begin
        if (13'(row_reg) < 13'(first_row_reg)) begin
            kind_next = PIX_CEIL;
        end else if (13'(row_reg) < 13'(end_row_reg)) begin
            kind_next = PIX_TEX;
        end else begin
            kind_next = PIX_FLOOR;
        end
        last_next  = (row_reg == ROW_W'(SCREEN_HEIGHT - 1));
        tex_addr   = STORE_AW'(face_reg) * STORE_AW'(FACE_WORDS)
                   + STORE_AW'({pos_reg[16 +: TEX_LOG2], tex_col_reg});
        paddr_next = 21'(row_reg) * 21'(SCREEN_WIDTH) + 21'(column_reg);
    end

    // multiplier operands: hit product, then start position
    always_comb begin
        if (state_reg == ST_POS) begin
            mul_a = offs_reg;
            mul_b = 32'(quo_reg);
        end else begin
            mul_a = perp_reg;
            mul_b = hit_dir_reg;
        end
        mul_full = 64'(mul_a) * 64'(mul_b);
    end

    // only the low 32 bits of the product matter for the hit fraction
    assign frac_next = hit_pos_reg + prod_reg[31:16];

    // restoring divider, one quotient bit per cycle
    always_comb begin
        div_bit  = (cnt_reg == DIV_CNT_W'(DIV_W - 1));
        div_sh   = {rem_reg, div_bit};
        div_q    = (div_sh >= {1'b0, lh_reg});
        rem_next = div_q ? 16'(div_sh - {1'b0, lh_reg}) : div_sh[15:0];
    end

    always_comb begin
        case (b_kind_reg)
            PIX_CEIL:  color_next = ceil_reg;
            PIX_TEX:   color_next = ram_rdata;
            PIX_FLOOR: color_next = floor_reg;
            default:   color_next = floor_reg;
        endcase
    end

    tcr_ram #(
        .WIDTH(32),
        .DEPTH(STORE_WORDS)
    ) u_tex_ram (
        .aclk  (aclk),
        .we    (do_load),
        .waddr (load_ptr_reg),
        .wdata (q_req.texel),
        .re    (issue && kind_next == PIX_TEX),
        .raddr (tex_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            load_ptr_reg <= '0;
            active_reg   <= 1'b0;
            row_reg      <= '0;
            ceil_reg     <= '0;
            floor_reg    <= '0;
            b_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_CEILING: ceil_reg  <= cfg_wdata;
                    CFG_FLOOR:   floor_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (do_load) begin
                load_ptr_reg <= (load_ptr_reg == STORE_AW'(STORE_WORDS - 1))
                              ? '0 : load_ptr_reg + 1'b1;
            end

            case (state_reg)
                ST_RUN: begin
                    if (do_start) begin
                        hit_pos_reg   <= q_req.hit_pos;
                        hit_dir_reg   <= q_req.hit_dir;
                        perp_reg      <= q_req.perp_dist;
                        lh_reg        <= q_req.line_height;
                        offs_reg      <= 32'(q_req.draw_start) + 32'(q_req.line_height >> 1)
                                       - 32'(HALF_HEIGHT);
                        first_row_reg <= q_req.draw_start;
                        end_row_reg   <= q_req.draw_end;
                        face_reg      <= q_req.face;
                        column_reg    <= q_req.column;
                        row_reg       <= '0;
                        active_reg    <= 1'b1;
                        state_reg     <= ST_MUL;
                    end else if (issue) begin
                        if (kind_next == PIX_TEX) begin
                            pos_reg <= pos_reg + step_reg;
                        end
                        if (last_next) begin
                            row_reg    <= '0;
                            active_reg <= 1'b0;
                        end else begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end
                end
                ST_MUL: begin
                    prod_reg  <= mul_full[31:0];
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= DIV_CNT_W'(DIV_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    tex_col_reg <= frac_next[15 -: TEX_LOG2];
                    rem_reg     <= rem_next;
                    quo_reg     <= {quo_reg[DIV_W-2:0], div_q};
                    cnt_reg     <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_POS;
                    end
                end
                ST_POS: begin
                    step_reg  <= 32'(quo_reg);
                    pos_reg   <= mul_full[31:0];
                    state_reg <= ST_RUN;
                end
                default: state_reg <= ST_RUN;
            endcase

            if (issue) begin
                b_valid_reg <= 1'b1;
                b_kind_reg  <= kind_next;
                b_paddr_reg <= paddr_next;
                b_last_reg  <= last_next;
            end else if (out_adv) begin
                b_valid_reg <= 1'b0;
            end

            if (out_adv) begin
                m_valid_reg      <= 1'b1;
                m_pixel_addr_reg <= b_paddr_reg;
                m_color_reg      <= color_next;
                m_last_reg       <= b_last_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_addr = m_pixel_addr_reg;
    assign m_color      = m_color_reg;
    assign m_last       = m_last_reg;

endmodule

### sv/textured_column_renderer.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_valid/s_ready    opcode, texel, ray hit and column request fields
// m_*       out  m_valid/m_ready    pixel_addr, color, last
// cfg_*     in   cfg_we (no wait)   cfg_idx, cfg_wdata: ceiling and floor colors
//
// Emit requests issue one pixel per cycle while m_ready does not stall the pixel pipe;
// a texel load is written into the store as it is popped from the queue.
// A start request holds the back end while it sets up the column: one multiply,
// the bit-serial step divider (one bit per cycle), and the start position multiply.
// A pixel passes through the queue, the read stage (issue and RAM read) and
// the output register.
// Reset (aresetn, synchronous, low) clears control, load pointer and colors;
// the texture store is not cleared and must be loaded before use.
// A stalled m_ready backs up the pixel pipe; an emit waiting at the queue head also holds back loads behind it.
module textured_column_renderer import tcr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [31:0]          s_texel_value,
    input  logic [10:0]          s_column,
    input  logic [1:0]           s_side,
    input  logic [9:0]           s_draw_start,
    input  logic [10:0]          s_draw_end,
    input  logic [15:0]          s_line_height,
    input  logic [31:0]          s_player_x,
    input  logic [31:0]          s_player_y,
    input  logic [31:0]          s_perp_dist,
    input  logic signed [31:0]   s_ray_dir_x,
    input  logic signed [31:0]   s_ray_dir_y,
    // pixel channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [20:0]          m_pixel_addr,
    output logic [31:0]          m_color,
    output logic                 m_last,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_wdata
);

    // front end -> back end queue head
    logic q_valid;
    req_t q_req;
    logic q_pop;

    // front: accept, decode opcode, pick hit axis, fold face; small queue
    tcr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_texel_value (s_texel_value),
        .s_column      (s_column),
        .s_side        (s_side),
        .s_draw_start  (s_draw_start),
        .s_draw_end    (s_draw_end),
        .s_line_height (s_line_height),
        .s_player_x    (s_player_x),
        .s_player_y    (s_player_y),
        .s_perp_dist   (s_perp_dist),
        .s_ray_dir_x   (s_ray_dir_x),
        .s_ray_dir_y   (s_ray_dir_y),
        .q_valid       (q_valid),
        .q_req         (q_req),
        .q_pop         (q_pop)
    );

    // back: texture store, column setup sequencer, pixel pipe
    tcr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_req        (q_req),
        .q_pop        (q_pop),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_addr (m_pixel_addr),
        .m_color      (m_color),
        .m_last       (m_last)
    );

endmodule
